// File: rtl/core/tile_map_store_and_locator_top_assert.svh
// assertion macros for the tile map store and locator
`ifndef TILE_MAP_STORE_AND_LOCATOR_TOP_ASSERT_SVH
`define TILE_MAP_STORE_AND_LOCATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define TMSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmsl: same-cycle check failed");
`define TMSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmsl: next-cycle check failed");
`else
`define TMSL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TMSL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/tmsl_pkg.sv
// shared types and constants of the tile map store and locator
`timescale 1ns / 1ps

package tmsl_pkg;

    localparam int MODE_W     = 2;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 7;
    localparam int VAL_W      = 16;
    localparam int LIN_W      = 13;
    localparam int STAT_W     = 2;
    localparam int ID_W       = 16;
    localparam int IDX_W      = 12;
    localparam int POS_W      = 14;
    localparam int CLIPX_W    = 20;
    localparam int CLIPY_W    = 24;
    localparam int CELL_W     = 14;
    localparam int MW_W       = 7;
    localparam int TW_W       = 9;
    localparam int AWD_W      = 13;
    localparam int PR_W       = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INFO  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTEX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_CHECK,
        ST_PR_START,
        ST_PR_WAIT,
        ST_LIN_START,
        ST_LIN_WAIT,
        ST_TID_START,
        ST_TID_WAIT,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        RES_RANGE,
        RES_NOTEX,
        RES_WRITE,
        RES_READ,
        RES_INFO
    } res_t;

    typedef enum logic [1:0] {
        DIV_PER_ROW,
        DIV_LIN,
        DIV_TID
    } div_op_t;

    typedef struct packed {
        logic    load;
        logic    calc_index;
        logic    mem_we;
        logic    mem_re;
        logic    clr_step;
        logic    div_start;
        div_op_t div_op;
        logic    cap_pr;
        logic    cap_lin;
        logic    cap_tid;
        logic    mul;
        logic    out_load;
        res_t    res;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              pos_ok;
        logic              lin_ok;
        logic              tw_zero;
        logic              div_busy;
        logic              div_done;
        logic              div_q_zero;
        logic              clr_last;
        logic              out_free;
    } dp_sts_t;

endpackage

// File: rtl/core/tmsl_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tmsl_div #(
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(DW);

    logic [DW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/core/tmsl_datapath.sv
// datapath: config registers, tile store, divider, multipliers and result register
`timescale 1ns / 1ps

module tmsl_datapath #(
    parameter int MAX_TILES = 4096,
    parameter int ID_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tmsl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tmsl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [tmsl_pkg::MODE_W-1:0]       in_mode,
    input  logic [tmsl_pkg::COL_W-1:0]        in_col,
    input  logic [tmsl_pkg::ROW_W-1:0]        in_row,
    input  logic [tmsl_pkg::VAL_W-1:0]        in_tile_value,
    input  logic [tmsl_pkg::LIN_W-1:0]        in_linear_index,
    input  tmsl_pkg::dp_cmd_t                 cmd,
    output tmsl_pkg::dp_sts_t                 sts,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [tmsl_pkg::STAT_W-1:0]       out_status,
    output logic [tmsl_pkg::ID_W-1:0]         out_tile_id,
    output logic [tmsl_pkg::IDX_W-1:0]        out_tile_index,
    output logic [tmsl_pkg::POS_W-1:0]        out_pos_x,
    output logic [tmsl_pkg::POS_W-1:0]        out_pos_y,
    output logic [tmsl_pkg::CLIPX_W-1:0]      out_clip_x,
    output logic [tmsl_pkg::CLIPY_W-1:0]      out_clip_y
);

    localparam int AW  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int DW  = (ID_BITS > tmsl_pkg::LIN_W) ? ID_BITS : tmsl_pkg::LIN_W;
    localparam int CYW = ID_BITS + tmsl_pkg::TW_W;
    localparam logic [16:0]   MAX_TILES_W = 17'(MAX_TILES);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(MAX_TILES - 1);

    // configuration
    logic [tmsl_pkg::MW_W-1:0]  mw_reg;
    logic [tmsl_pkg::MW_W-1:0]  mh_reg;
    logic [tmsl_pkg::TW_W-1:0]  tw_reg;
    logic [tmsl_pkg::TW_W-1:0]  th_reg;
    logic [tmsl_pkg::AWD_W-1:0] aw_reg;

    // request fields
    logic [tmsl_pkg::MODE_W-1:0] mode_reg;
    logic [tmsl_pkg::COL_W-1:0]  col_reg;
    logic [tmsl_pkg::ROW_W-1:0]  row_reg;
    logic [tmsl_pkg::VAL_W-1:0]  val_reg;
    logic [tmsl_pkg::LIN_W-1:0]  lin_reg;

    logic [tmsl_pkg::CELL_W-1:0] idx_reg;
    logic [tmsl_pkg::CELL_W-1:0] cells_reg;
    logic [tmsl_pkg::CELL_W-1:0] idx_next;
    logic [tmsl_pkg::CELL_W-1:0] cells_next;

    // tile store
    logic [ID_BITS-1:0] mem [MAX_TILES];
    logic [ID_BITS-1:0] rd_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [AW-1:0]      mem_addr;
    logic [ID_BITS-1:0] mem_wdata;
    logic               mem_we_i;
    logic [16:0]        idx_wide;
    logic [16:0]        lin_wide;
    logic [31:0]        val_wide;

    // divider
    logic [31:0]   dvd_wide;
    logic [31:0]   dvs_wide;
    logic          div_busy;
    logic          div_done;
    logic [DW-1:0] div_q;
    logic [DW-1:0] div_r;

    logic [tmsl_pkg::PR_W-1:0]  per_row_reg;
    logic [tmsl_pkg::LIN_W-1:0] lin_q_reg;
    logic [tmsl_pkg::MW_W-1:0]  lin_r_reg;
    logic [ID_BITS-1:0]         tid_q_reg;
    logic [tmsl_pkg::PR_W-1:0]  tid_r_reg;

    // products
    logic [15:0]     px_full;
    logic [21:0]     py_full;
    logic [21:0]     cx_full;
    logic [CYW-1:0]  cy_full;
    logic [39:0]     cy_ext;
    logic [tmsl_pkg::POS_W-1:0]   px_reg;
    logic [tmsl_pkg::POS_W-1:0]   py_reg;
    logic [tmsl_pkg::CLIPX_W-1:0] cx_reg;
    logic [tmsl_pkg::CLIPY_W-1:0] cy_reg;

    // result register
    logic [31:0]                  id_wide;
    logic                         out_valid_reg;
    logic [tmsl_pkg::STAT_W-1:0]  status_reg;
    logic [tmsl_pkg::ID_W-1:0]    tile_id_reg;
    logic [tmsl_pkg::IDX_W-1:0]   tile_index_reg;
    logic [tmsl_pkg::POS_W-1:0]   pos_x_reg;
    logic [tmsl_pkg::POS_W-1:0]   pos_y_reg;
    logic [tmsl_pkg::CLIPX_W-1:0] clip_x_reg;
    logic [tmsl_pkg::CLIPY_W-1:0] clip_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mw_reg <= 7'd64;
            mh_reg <= 7'd64;
            tw_reg <= 9'd16;
            th_reg <= 9'd16;
            aw_reg <= 13'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tmsl_pkg::CFG_MAP_WIDTH:   mw_reg <= cfg_data[tmsl_pkg::MW_W-1:0];
                tmsl_pkg::CFG_MAP_HEIGHT:  mh_reg <= cfg_data[tmsl_pkg::MW_W-1:0];
                tmsl_pkg::CFG_TILE_WIDTH:  tw_reg <= cfg_data[tmsl_pkg::TW_W-1:0];
                tmsl_pkg::CFG_TILE_HEIGHT: th_reg <= cfg_data[tmsl_pkg::TW_W-1:0];
                tmsl_pkg::CFG_ATLAS_WIDTH: aw_reg <= cfg_data[tmsl_pkg::AWD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            col_reg  <= in_col;
            row_reg  <= in_row;
            val_reg  <= in_tile_value;
            lin_reg  <= in_linear_index;
        end
    end

    assign idx_next   = tmsl_pkg::CELL_W'(row_reg) * tmsl_pkg::CELL_W'(mw_reg)
                      + tmsl_pkg::CELL_W'(col_reg);
    assign cells_next = tmsl_pkg::CELL_W'(mw_reg) * tmsl_pkg::CELL_W'(mh_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.calc_index)
        begin
            idx_reg   <= idx_next;
            cells_reg <= cells_next;
        end
    end

    assign idx_wide = 17'(idx_reg);
    assign lin_wide = 17'(lin_reg);
    assign val_wide = 32'(val_reg);

    always_comb
    begin
        mem_we_i  = cmd.mem_we || cmd.clr_step;
        mem_wdata = cmd.clr_step ? '0 : val_wide[ID_BITS-1:0];
        if (cmd.clr_step)
        begin
            mem_addr = clr_addr_reg;
        end
        else if (mode_reg == tmsl_pkg::MODE_INFO)
        begin
            mem_addr = lin_wide[AW-1:0];
        end
        else
        begin
            mem_addr = idx_wide[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we_i)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_re)
        begin
            rd_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.div_op)
            tmsl_pkg::DIV_PER_ROW:
            begin
                dvd_wide = 32'(aw_reg);
                dvs_wide = 32'(tw_reg);
            end
            tmsl_pkg::DIV_LIN:
            begin
                dvd_wide = 32'(lin_reg);
                dvs_wide = 32'(mw_reg);
            end
            tmsl_pkg::DIV_TID:
            begin
                dvd_wide = 32'(rd_reg);
                dvs_wide = 32'(per_row_reg);
            end
            default:
            begin
                dvd_wide = '0;
                dvs_wide = '0;
            end
        endcase
    end

    tmsl_div #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd_wide[DW-1:0]),
        .divisor   (dvs_wide[DW-1:0]),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cap_pr)
        begin
            per_row_reg <= div_q[tmsl_pkg::PR_W-1:0];
        end
        if (cmd.cap_lin)
        begin
            lin_q_reg <= div_q[tmsl_pkg::LIN_W-1:0];
            lin_r_reg <= div_r[tmsl_pkg::MW_W-1:0];
        end
        if (cmd.cap_tid)
        begin
            tid_q_reg <= div_q[ID_BITS-1:0];
            tid_r_reg <= div_r[tmsl_pkg::PR_W-1:0];
        end
    end

    assign px_full = 16'(lin_r_reg) * 16'(tw_reg);
    assign py_full = 22'(lin_q_reg) * 22'(th_reg);
    assign cx_full = 22'(tid_r_reg) * 22'(tw_reg);
    assign cy_full = CYW'(tid_q_reg) * CYW'(th_reg);
    assign cy_ext  = 40'(cy_full);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            px_reg <= px_full[tmsl_pkg::POS_W-1:0];
            py_reg <= py_full[tmsl_pkg::POS_W-1:0];
            cx_reg <= cx_full[tmsl_pkg::CLIPX_W-1:0];
            cy_reg <= cy_ext[tmsl_pkg::CLIPY_W-1:0];
        end
    end

    assign id_wide = 32'(rd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg     <= tmsl_pkg::STAT_OK;
            tile_id_reg    <= '0;
            tile_index_reg <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            clip_x_reg     <= '0;
            clip_y_reg     <= '0;
            case (cmd.res)
                tmsl_pkg::RES_RANGE: status_reg <= tmsl_pkg::STAT_RANGE;
                tmsl_pkg::RES_NOTEX: status_reg <= tmsl_pkg::STAT_NOTEX;
                tmsl_pkg::RES_WRITE: status_reg <= tmsl_pkg::STAT_OK;
                tmsl_pkg::RES_READ:
                begin
                    tile_id_reg    <= id_wide[tmsl_pkg::ID_W-1:0];
                    tile_index_reg <= idx_reg[tmsl_pkg::IDX_W-1:0];
                end
                tmsl_pkg::RES_INFO:
                begin
                    tile_id_reg <= id_wide[tmsl_pkg::ID_W-1:0];
                    pos_x_reg   <= px_reg;
                    pos_y_reg   <= py_reg;
                    clip_x_reg  <= cx_reg;
                    clip_y_reg  <= cy_reg;
                end
                default: status_reg <= tmsl_pkg::STAT_RANGE;
            endcase
        end
    end

    assign sts.mode       = mode_reg;
    assign sts.pos_ok     = (col_reg < mw_reg) && (row_reg < mh_reg)
                          && (idx_wide < MAX_TILES_W);
    assign sts.lin_ok     = (tmsl_pkg::CELL_W'(lin_reg) < cells_reg)
                          && (lin_wide < MAX_TILES_W);
    assign sts.tw_zero    = (tw_reg == '0);
    assign sts.div_busy   = div_busy;
    assign sts.div_done   = div_done;
    assign sts.div_q_zero = (div_q == '0);
    assign sts.clr_last   = (clr_addr_reg == LAST_ADDR);
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign out_status     = status_reg;
    assign out_tile_id    = tile_id_reg;
    assign out_tile_index = tile_index_reg;
    assign out_pos_x      = pos_x_reg;
    assign out_pos_y      = pos_y_reg;
    assign out_clip_x     = clip_x_reg;
    assign out_clip_y     = clip_y_reg;

endmodule

// File: rtl/core/tmsl_ctrl.sv
// controller state machine sequencing the datapath for each request
`timescale 1ns / 1ps

module tmsl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tmsl_pkg::dp_sts_t sts,
    output tmsl_pkg::dp_cmd_t cmd
);

    tmsl_pkg::state_t state_reg;
    tmsl_pkg::state_t state_next;
    tmsl_pkg::res_t   res_reg;
    tmsl_pkg::res_t   res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmsl_pkg::ST_CLEAR;
            res_reg   <= tmsl_pkg::RES_RANGE;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        case (state_reg)
            tmsl_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = tmsl_pkg::ST_IDLE;
                end
            end
            tmsl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tmsl_pkg::ST_INDEX;
                end
            end
            tmsl_pkg::ST_INDEX:
            begin
                state_next = tmsl_pkg::ST_CHECK;
            end
            tmsl_pkg::ST_CHECK:
            begin
                state_next = tmsl_pkg::ST_DONE;
                res_next   = tmsl_pkg::RES_RANGE;
                case (sts.mode)
                    tmsl_pkg::MODE_WRITE:
                    begin
                        if (sts.pos_ok)
                        begin
                            res_next = tmsl_pkg::RES_WRITE;
                        end
                    end
                    tmsl_pkg::MODE_READ:
                    begin
                        if (sts.pos_ok)
                        begin
                            res_next = tmsl_pkg::RES_READ;
                        end
                    end
                    tmsl_pkg::MODE_INFO:
                    begin
                        if (sts.lin_ok && sts.tw_zero)
                        begin
                            res_next = tmsl_pkg::RES_NOTEX;
                        end
                        else if (sts.lin_ok)
                        begin
                            state_next = tmsl_pkg::ST_PR_START;
                        end
                    end
                    default: ;
                endcase
            end
            tmsl_pkg::ST_PR_START:
            begin
                state_next = tmsl_pkg::ST_PR_WAIT;
            end
            tmsl_pkg::ST_PR_WAIT:
            begin
                if (sts.div_done && sts.div_q_zero)
                begin
                    res_next   = tmsl_pkg::RES_NOTEX;
                    state_next = tmsl_pkg::ST_DONE;
                end
                else if (sts.div_done)
                begin
                    state_next = tmsl_pkg::ST_LIN_START;
                end
            end
            tmsl_pkg::ST_LIN_START:
            begin
                state_next = tmsl_pkg::ST_LIN_WAIT;
            end
            tmsl_pkg::ST_LIN_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = tmsl_pkg::ST_TID_START;
                end
            end
            tmsl_pkg::ST_TID_START:
            begin
                state_next = tmsl_pkg::ST_TID_WAIT;
            end
            tmsl_pkg::ST_TID_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = tmsl_pkg::ST_MUL;
                end
            end
            tmsl_pkg::ST_MUL:
            begin
                res_next   = tmsl_pkg::RES_INFO;
                state_next = tmsl_pkg::ST_DONE;
            end
            tmsl_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = tmsl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmsl_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.calc_index = 1'b0;
        cmd.mem_we     = 1'b0;
        cmd.mem_re     = 1'b0;
        cmd.clr_step   = 1'b0;
        cmd.div_start  = 1'b0;
        cmd.div_op     = tmsl_pkg::DIV_PER_ROW;
        cmd.cap_pr     = 1'b0;
        cmd.cap_lin    = 1'b0;
        cmd.cap_tid    = 1'b0;
        cmd.mul        = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.res        = res_reg;
        case (state_reg)
            tmsl_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            tmsl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tmsl_pkg::ST_INDEX:
            begin
                cmd.calc_index = 1'b1;
            end
            tmsl_pkg::ST_CHECK:
            begin
                case (sts.mode)
                    tmsl_pkg::MODE_WRITE: cmd.mem_we = sts.pos_ok;
                    tmsl_pkg::MODE_READ:  cmd.mem_re = sts.pos_ok;
                    tmsl_pkg::MODE_INFO:  cmd.mem_re = sts.lin_ok && !sts.tw_zero;
                    default: ;
                endcase
            end
            tmsl_pkg::ST_PR_START:
            begin
                cmd.div_start = 1'b1;
            end
            tmsl_pkg::ST_PR_WAIT:
            begin
                cmd.cap_pr = sts.div_done;
            end
            tmsl_pkg::ST_LIN_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = tmsl_pkg::DIV_LIN;
            end
            tmsl_pkg::ST_LIN_WAIT:
            begin
                cmd.div_op  = tmsl_pkg::DIV_LIN;
                cmd.cap_lin = sts.div_done;
            end
            tmsl_pkg::ST_TID_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = tmsl_pkg::DIV_TID;
            end
            tmsl_pkg::ST_TID_WAIT:
            begin
                cmd.div_op  = tmsl_pkg::DIV_TID;
                cmd.cap_tid = sts.div_done;
            end
            tmsl_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            tmsl_pkg::ST_DONE:
            begin
                cmd.out_load = sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: rtl/core/tile_map_store_and_locator_top.sv
// tile map store and locator: top level
`timescale 1ns / 1ps
`include "tile_map_store_and_locator_top_assert.svh"

// Stores a map of tile ids and answers one result per request.
// Request channel s_*: s_tuser carries the mode (0 write, 1 read, 2 tile
// info by linear index), s_tdata carries col, row, tile_value, linear_index.
// Result channel m_*: m_tuser carries the status, m_tdata the tile id,
// linear index, pixel position and atlas clip position.
// Config port: cfg_we writes register cfg_index (0 map_width, 1 map_height,
// 2 tile_width, 3 tile_height, 4 atlas_width) from cfg_data. The user must write it only
// while idle; the block does not enforce this. One request at a time. Write and read
// requests pass through the index, check and done states from accept to m_tvalid;
// tile info requests run three divisions on one shared restoring divider of
// DW = max(13, ID_BITS) bits. The divider sets the tile info rate.
// After reset the tile store is swept to zero, one entry a cycle, over all
// MAX_TILES entries (4096 by default); s_tready stays low meanwhile.
// The result register lets the next request be accepted while a result
// waits on m_tready; that request then holds at its end until the result
// is taken.
module tile_map_store_and_locator_top #(
    parameter int MAX_TILES = 4096,
    parameter int ID_BITS   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tmsl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmsl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [47:0]                      s_tdata,  // col, row, tile_value, linear_index
    input  logic [1:0]                       s_tuser,  // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [103:0]                     m_tdata,  // tile_id, tile_index, pos_x, pos_y,
                                                       // clip_x, clip_y
    output logic [1:0]                       m_tuser   // status
);

    tmsl_pkg::dp_cmd_t cmd;
    tmsl_pkg::dp_sts_t sts;

    logic [tmsl_pkg::STAT_W-1:0]  status;
    logic [tmsl_pkg::ID_W-1:0]    tile_id;
    logic [tmsl_pkg::IDX_W-1:0]   tile_index;
    logic [tmsl_pkg::POS_W-1:0]   pos_x;
    logic [tmsl_pkg::POS_W-1:0]   pos_y;
    logic [tmsl_pkg::CLIPX_W-1:0] clip_x;
    logic [tmsl_pkg::CLIPY_W-1:0] clip_y;

    tmsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tmsl_datapath #(
        .MAX_TILES (MAX_TILES),
        .ID_BITS   (ID_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_mode         (s_tuser),
        .in_col          (s_tdata[6:0]),
        .in_row          (s_tdata[13:7]),
        .in_tile_value   (s_tdata[29:14]),
        .in_linear_index (s_tdata[42:30]),
        .cmd             (cmd),
        .sts             (sts),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_status      (status),
        .out_tile_id     (tile_id),
        .out_tile_index  (tile_index),
        .out_pos_x       (pos_x),
        .out_pos_y       (pos_y),
        .out_clip_x      (clip_x),
        .out_clip_y      (clip_y)
    );

    assign m_tuser = status;
    assign m_tdata = {4'b0, clip_y, clip_x, pos_y, pos_x, tile_index, tile_id};

    // no request taken while the store is being cleared
    `TMSL_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, cmd.clr_step, !s_tready)
    // a result is loaded only when the previous one is gone
    `TMSL_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, cmd.out_load, !m_tvalid || m_tready)
    // the divider is started only when idle
    `TMSL_ASSERT_IMP(a_div_start_idle, clk, rst_n, cmd.div_start, !sts.div_busy)
    // one request in flight at a time
    `TMSL_ASSERT_NXT(a_single_request, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

// File: tb/tile_map_result_checker.sv
// checker for the tile map store and locator: predicts each result and compares it
`timescale 1ns / 1ps

module tile_map_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tmsl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmsl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [47:0]                      s_tdata,  // col, row, tile_value, linear_index
    input  logic [1:0]                       s_tuser,  // mode
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [103:0]                     m_tdata,  // tile_id, tile_index, pos_x, pos_y,
                                                       // clip_x, clip_y
    input  logic [1:0]                       m_tuser,  // status
    output int                               fail_count,
    output int                               pending
);

    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = 12;

    typedef struct packed {
        logic [tmsl_pkg::STAT_W-1:0]  status;
        logic [tmsl_pkg::ID_W-1:0]    tile_id;
        logic [tmsl_pkg::IDX_W-1:0]   tile_index;
        logic [tmsl_pkg::POS_W-1:0]   pos_x;
        logic [tmsl_pkg::POS_W-1:0]   pos_y;
        logic [tmsl_pkg::CLIPX_W-1:0] clip_x;
        logic [tmsl_pkg::CLIPY_W-1:0] clip_y;
    } tile_result_t;

    logic [tmsl_pkg::ID_W-1:0]  tile_map [0:STORE_DEPTH-1];
    logic [tmsl_pkg::MW_W-1:0]  map_w;
    logic [tmsl_pkg::MW_W-1:0]  map_h;
    logic [tmsl_pkg::TW_W-1:0]  tile_w;
    logic [tmsl_pkg::TW_W-1:0]  tile_h;
    logic [tmsl_pkg::AWD_W-1:0] atlas_w;
    tile_result_t               result_q [$];
    int                         mismatches = 0;
    int                         queued = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    // applies one request to the map copy and returns the result it should give
    function automatic tile_result_t serve_request(
        input logic [tmsl_pkg::MODE_W-1:0] mode,
        input logic [tmsl_pkg::COL_W-1:0]  col,
        input logic [tmsl_pkg::ROW_W-1:0]  row,
        input logic [tmsl_pkg::VAL_W-1:0]  value,
        input logic [tmsl_pkg::LIN_W-1:0]  lin);
        tile_result_t    r;
        longint unsigned mw;
        longint unsigned mh;
        longint unsigned tw;
        longint unsigned th;
        longint unsigned lin_l;
        longint unsigned idx;
        longint unsigned cells;
        longint unsigned per_row;
        longint unsigned tid;
        r        = '0;
        r.status = tmsl_pkg::STAT_RANGE;
        mw       = 64'(map_w);
        mh       = 64'(map_h);
        tw       = 64'(tile_w);
        th       = 64'(tile_h);
        lin_l    = 64'(lin);
        if (mode == tmsl_pkg::MODE_WRITE || mode == tmsl_pkg::MODE_READ)
        begin
            idx = 64'(row) * mw + 64'(col);
            if (col < map_w && row < map_h && idx < 64'(STORE_DEPTH))
            begin
                r.status = tmsl_pkg::STAT_OK;
                if (mode == tmsl_pkg::MODE_WRITE)
                begin
                    tile_map[idx[STORE_AW-1:0]] = value;
                end
                else
                begin
                    r.tile_id    = tile_map[idx[STORE_AW-1:0]];
                    r.tile_index = idx[tmsl_pkg::IDX_W-1:0];
                end
            end
        end
        else if (mode == tmsl_pkg::MODE_INFO)
        begin
            cells = mw * mh;
            if (lin_l < cells && lin_l < 64'(STORE_DEPTH))
            begin
                per_row = (tw != 64'd0) ? 64'(atlas_w) / tw : 64'd0;
                if (per_row == 64'd0)
                begin
                    r.status = tmsl_pkg::STAT_NOTEX;
                end
                else
                begin
                    // lin below the cell count means map_w is nonzero
                    tid       = 64'(tile_map[lin[STORE_AW-1:0]]);
                    r.status  = tmsl_pkg::STAT_OK;
                    r.tile_id = tid[tmsl_pkg::ID_W-1:0];
                    r.pos_x   = tmsl_pkg::POS_W'((lin_l % mw) * tw);
                    r.pos_y   = tmsl_pkg::POS_W'((lin_l / mw) * th);
                    r.clip_x  = tmsl_pkg::CLIPX_W'((tid % per_row) * tw);
                    r.clip_y  = tmsl_pkg::CLIPY_W'((tid / per_row) * th);
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches = mismatches + 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tile_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                tile_map[STORE_AW'(i)] = '0;
            end
            map_w   = 7'd64;
            map_h   = 7'd64;
            tile_w  = 9'd16;
            tile_h  = 9'd16;
            atlas_w = '0;
            result_q.delete();
            queued <= 0;
        end
        else
        begin
            // results first so a stray result never pairs with a request of this edge
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual status %0d data %h",
                             $time, m_tuser, m_tdata);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("status",     64'(want.status),     64'(m_tuser));
                    check_field("tile_id",    64'(want.tile_id),    64'(m_tdata[15:0]));
                    check_field("tile_index", 64'(want.tile_index), 64'(m_tdata[27:16]));
                    check_field("pos_x",      64'(want.pos_x),      64'(m_tdata[41:28]));
                    check_field("pos_y",      64'(want.pos_y),      64'(m_tdata[55:42]));
                    check_field("clip_x",     64'(want.clip_x),     64'(m_tdata[75:56]));
                    check_field("clip_y",     64'(want.clip_y),     64'(m_tdata[99:76]));
                    check_field("tdata pad",  64'd0,                64'(m_tdata[103:100]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                result_q.push_back(serve_request(s_tuser, s_tdata[6:0], s_tdata[13:7],
                                                 s_tdata[29:14], s_tdata[42:30]));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    tmsl_pkg::CFG_MAP_WIDTH:   map_w   = cfg_data[tmsl_pkg::MW_W-1:0];
                    tmsl_pkg::CFG_MAP_HEIGHT:  map_h   = cfg_data[tmsl_pkg::MW_W-1:0];
                    tmsl_pkg::CFG_TILE_WIDTH:  tile_w  = cfg_data[tmsl_pkg::TW_W-1:0];
                    tmsl_pkg::CFG_TILE_HEIGHT: tile_h  = cfg_data[tmsl_pkg::TW_W-1:0];
                    tmsl_pkg::CFG_ATLAS_WIDTH: atlas_w = cfg_data[tmsl_pkg::AWD_W-1:0];
                    default: ;
                endcase
            end
            queued <= result_q.size();
        end
    end

endmodule

// File: tb/tb_tile_map_store_and_locator_top.sv
// testbench top for the tile map store and locator: stimulus, config phases and verdict
`timescale 1ns / 1ps

module tb_tile_map_store_and_locator_top;

    localparam logic [tmsl_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int RANDOM_REQUESTS = 1950;
    localparam int NUM_PHASES      = 10;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [tmsl_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tmsl_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [47:0]                     s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [103:0]                    m_tdata;
    logic [1:0]                      m_tuser;
    int                              fail_count;
    int                              pending;

    bit          calm = 1'b0;
    int          gap_pct = 25;
    int unsigned cur_mw = 64;
    int unsigned cur_mh = 64;
    int unsigned cur_tw = 16;
    int unsigned cur_th = 16;
    int unsigned cur_aw = 0;

    tile_map_store_and_locator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    tile_map_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #8_000_000;
        $display("tb_tile_map_store_and_locator_top failed");
        $finish;
    end

    // result side: stall bursts between ready runs, none once calm
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    task automatic write_reg(input logic [tmsl_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= tmsl_pkg::CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic program_regs(input int unsigned mw, input int unsigned mh,
                                input int unsigned tw, input int unsigned th,
                                input int unsigned aw);
        write_reg(tmsl_pkg::CFG_MAP_WIDTH, mw);
        write_reg(tmsl_pkg::CFG_MAP_HEIGHT, mh);
        write_reg(tmsl_pkg::CFG_TILE_WIDTH, tw);
        write_reg(tmsl_pkg::CFG_TILE_HEIGHT, th);
        write_reg(tmsl_pkg::CFG_ATLAS_WIDTH, aw);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_mw = mw;
        cur_mh = mh;
        cur_tw = tw;
        cur_th = th;
        cur_aw = aw;
    endtask

    // holds off until every result has been taken, plus a short settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_request(input logic [tmsl_pkg::MODE_W-1:0] mode,
                                input logic [tmsl_pkg::COL_W-1:0]  col,
                                input logic [tmsl_pkg::ROW_W-1:0]  row,
                                input logic [tmsl_pkg::VAL_W-1:0]  value,
                                input logic [tmsl_pkg::LIN_W-1:0]  lin);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {5'b0, lin, value, row, col};
        do @(posedge clk); while (s_tready !== 1'b1);
        if (!calm && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // mostly in-range requests, many in a small hot corner so reads find written ids
    task automatic send_random_request();
        int unsigned                   sel;
        int unsigned                   hot_w;
        int unsigned                   hot_h;
        int unsigned                   cells;
        logic [tmsl_pkg::MODE_W-1:0]   mode;
        logic [tmsl_pkg::COL_W-1:0]    col;
        logic [tmsl_pkg::ROW_W-1:0]    row;
        logic [tmsl_pkg::VAL_W-1:0]    value;
        logic [tmsl_pkg::LIN_W-1:0]    lin;
        hot_w = (cur_mw < 8) ? cur_mw : 8;
        hot_h = (cur_mh < 8) ? cur_mh : 8;
        cells = cur_mw * cur_mh;
        if (cells > 4096) cells = 4096;
        sel  = $urandom_range(0, 99);
        mode = (sel < 35) ? tmsl_pkg::MODE_WRITE : (sel < 60) ? tmsl_pkg::MODE_READ :
               (sel < 94) ? tmsl_pkg::MODE_INFO : MODE_SPARE;
        col   = tmsl_pkg::COL_W'($urandom_range(0, 127));
        row   = tmsl_pkg::ROW_W'($urandom_range(0, 127));
        value = tmsl_pkg::VAL_W'($urandom_range(0, 65535));
        lin   = tmsl_pkg::LIN_W'($urandom_range(0, 8191));
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            col = tmsl_pkg::COL_W'($urandom_range(0, hot_w - 1));
            row = tmsl_pkg::ROW_W'($urandom_range(0, hot_h - 1));
        end
        else if (sel < 85)
        begin
            col = tmsl_pkg::COL_W'($urandom_range(0, cur_mw - 1));
            row = tmsl_pkg::ROW_W'($urandom_range(0, cur_mh - 1));
        end
        sel = $urandom_range(0, 99);
        if (sel < 45)
            lin = tmsl_pkg::LIN_W'($urandom_range(0, hot_h - 1) * cur_mw
                                   + $urandom_range(0, hot_w - 1));
        else if (sel < 85)
            lin = tmsl_pkg::LIN_W'($urandom_range(0, cells - 1));
        if ($urandom_range(0, 4) == 0) value = tmsl_pkg::VAL_W'($urandom_range(0, 15));
        send_request(mode, col, row, value, lin);
    endtask

    task automatic program_random_regs();
        int unsigned tw;
        int unsigned aw;
        int unsigned sel;
        tw  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 32);
        sel = $urandom_range(0, 7);
        if (sel == 0)
            aw = 0;
        else if (sel == 1)
            aw = $urandom_range(0, 4096);
        else
        begin
            aw = tw * $urandom_range(1, 32) + $urandom_range(0, tw - 1);
            if (aw > 4096) aw = 4096;
        end
        program_regs($urandom_range(1, 64), $urandom_range(1, 64), tw,
                     $urandom_range(1, 256), aw);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= tmsl_pkg::CFG_MAP_WIDTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= tmsl_pkg::MODE_WRITE;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 64x64 map, no atlas
        send_request(tmsl_pkg::MODE_READ, 7'd0, 7'd0, 16'h0000, 13'd0);
        send_request(tmsl_pkg::MODE_WRITE, 7'd63, 7'd63, 16'hFFFF, 13'd0);
        send_request(tmsl_pkg::MODE_READ, 7'd63, 7'd63, 16'h0000, 13'd0);
        send_request(tmsl_pkg::MODE_WRITE, 7'd0, 7'd0, 16'hA5A5, 13'h1FFF);
        send_request(tmsl_pkg::MODE_WRITE, 7'd127, 7'd127, 16'h1234, 13'd0);
        send_request(tmsl_pkg::MODE_READ, 7'd64, 7'd0, 16'h0000, 13'd0);
        send_request(tmsl_pkg::MODE_READ, 7'd0, 7'd64, 16'h0000, 13'd0);
        send_request(tmsl_pkg::MODE_INFO, 7'd0, 7'd0, 16'h0000, 13'd0);
        send_request(tmsl_pkg::MODE_INFO, 7'd0, 7'd0, 16'h0000, 13'd8191);
        send_request(tmsl_pkg::MODE_INFO, 7'd0, 7'd0, 16'h0000, 13'd4096);
        send_request(MODE_SPARE, 7'd127, 7'd127, 16'hFFFF, 13'h1FFF);
        wait_drained();

        // widest atlas, thinnest tiles
        program_regs(64, 64, 1, 256, 4096);
        send_request(tmsl_pkg::MODE_INFO, 7'd0, 7'd0, 16'h0000, 13'd4095);
        send_request(tmsl_pkg::MODE_INFO, 7'd0, 7'd0, 16'h0000, 13'd0);
        wait_drained();

        // atlas narrower than one tile
        program_regs(64, 64, 256, 256, 255);
        send_request(tmsl_pkg::MODE_INFO, 7'd0, 7'd0, 16'h0000, 13'd0);
        wait_drained();

        // single-cell map
        program_regs(1, 1, 256, 1, 4096);
        send_request(tmsl_pkg::MODE_WRITE, 7'd0, 7'd0, 16'h5A5A, 13'd0);
        send_request(tmsl_pkg::MODE_READ, 7'd1, 7'd0, 16'h0000, 13'd0);
        send_request(tmsl_pkg::MODE_READ, 7'd0, 7'd0, 16'h0000, 13'd0);
        send_request(tmsl_pkg::MODE_INFO, 7'd0, 7'd0, 16'h0000, 13'd0);
        send_request(tmsl_pkg::MODE_INFO, 7'd0, 7'd0, 16'h0000, 13'd1);
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: program_regs(64, 64, 256, 256, 4096);
                1: program_regs(1, 1, 1, 1, 1);
                2: program_regs(64, 1, 1, 256, 0);
                3: program_regs(1, 64, 256, 1, 256);
                default: program_random_regs();
            endcase
            calm    = (phase == NUM_PHASES - 1);
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            repeat (RANDOM_REQUESTS / NUM_PHASES) send_random_request();
            wait_drained();
        end

        if (fail_count == 0 && pending == 0)
            $display("tb_tile_map_store_and_locator_top passed");
        else
            $display("tb_tile_map_store_and_locator_top failed");
        $finish;
    end

endmodule
